>>> src/gtr_pkg.sv
// Package for the glyph text renderer: shared constants, types and helpers.
// No dependencies.
`timescale 1ns / 1ps

package gtr_pkg;

  localparam int GTR_TABLE_ENTRIES = 256;
  localparam int GTR_GLYPH_DIM     = 8;

  localparam int CFG_W    = 9;
  localparam int SLOT_W   = 8;
  localparam int CODE_W   = 16;
  localparam int DIM_W    = 4;
  localparam int SIZE_W   = 6;
  localparam int BITMAP_W = 64;
  localparam int ORIGIN_W = 12;
  localparam int COLOR_W  = 24;
  localparam int PIX_W    = 13;
  localparam int POS_W    = 6;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [SIZE_W-1:0]   size;   // [2:0] width-1, [5:3] height-1
    logic [BITMAP_W-1:0] bits;
  } gtr_entry_t;

  typedef struct packed {
    logic done;
    logic found;
  } gtr_hit_t;

  // Clamp a glyph dimension to 1..dim and return it minus one.
  function automatic logic [2:0] clamp_dim_m1(logic [DIM_W-1:0] v, int dim);
    logic [2:0] r;
    if (v == '0) begin
      r = 3'd0;
    end else if (int'(v) > dim) begin
      r = 3'(dim - 1);
    end else begin
      r = 3'(v - 4'd1);
    end
    return r;
  endfunction

endpackage

>>> src/gtr_req_if.sv
// Request channel interface of the glyph text renderer (load and draw items).
// Depends on gtr_pkg.
`timescale 1ns / 1ps

interface gtr_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [gtr_pkg::SLOT_W-1:0]      entry_index;
  logic [gtr_pkg::CODE_W-1:0]      entry_code;
  logic [gtr_pkg::DIM_W-1:0]       glyph_width;
  logic [gtr_pkg::DIM_W-1:0]       glyph_height;
  logic [gtr_pkg::BITMAP_W-1:0]    glyph_bits;
  logic [gtr_pkg::CODE_W-1:0]      char_code;
  logic [gtr_pkg::ORIGIN_W-1:0]    origin_x;
  logic [gtr_pkg::ORIGIN_W-1:0]    origin_y;
  logic [gtr_pkg::COLOR_W-1:0]     ink_color;

  modport source (
    output valid, req_type, entry_index, entry_code, glyph_width, glyph_height,
           glyph_bits, char_code, origin_x, origin_y, ink_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_code, glyph_width, glyph_height,
           glyph_bits, char_code, origin_x, origin_y, ink_color,
    output ready
  );
endinterface

>>> src/gtr_pix_if.sv
// Pixel write channel interface of the glyph text renderer.
// Depends on gtr_pkg.
`timescale 1ns / 1ps

interface gtr_pix_if;
  logic                         valid;
  logic                         ready;
  logic [gtr_pkg::PIX_W-1:0]    pixel_x;
  logic [gtr_pkg::PIX_W-1:0]    pixel_y;
  logic [gtr_pkg::COLOR_W-1:0]  pixel_color;
  logic                         pixel_valid;
  logic                         glyph_found;
  logic                         last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, pixel_valid, glyph_found, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, pixel_valid, glyph_found, last,
    output ready
  );
endinterface

>>> src/glyph_text_renderer_core.sv
// Top level of the glyph text renderer: request decode, glyph table,
// binary search sequencer and dot scanner. Depends on gtr_pkg, gtr_req_if,
// gtr_pix_if, gtr_glyph_mem, gtr_search, gtr_dot_scan.
//
//   channel   dir  handshake     carries
//   req_i     in   valid/ready   load entry or draw character item
//   pix_o     out  valid/ready   pixel write item, last marks end of a draw
//   cfg       in   cfg_we_i      entry_count (9 bits)
//
// Load: no result. Draw: accept, then search probes (each a registered table
// read in states S_PROBE and S_CMP of gtr_search, up to log2(count)+1
// probes), then one bitmap position per cycle up to the last set dot (at
// most 64) unless pix_o stalls, or a single not-valid item, then back to idle.
// Reset clears control and entry_count; table contents are undefined until
// loaded. A stalled pix_o holds the scanner; req_i is ready only when idle.
`timescale 1ns / 1ps

module glyph_text_renderer_core #(
  parameter int TABLE_ENTRIES = gtr_pkg::GTR_TABLE_ENTRIES,
  parameter int GLYPH_DIM     = gtr_pkg::GTR_GLYPH_DIM
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gtr_pkg::CFG_W-1:0]   cfg_wdata_i,
  gtr_req_if.sink                     req_i,
  gtr_pix_if.source                   pix_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CMP_W = (IDX_W + 1 > gtr_pkg::SLOT_W) ? IDX_W + 1 : gtr_pkg::SLOT_W + 1;

  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_SEARCH = 2'd1;
  localparam logic [1:0] T_SCAN   = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [gtr_pkg::CFG_W-1:0]       count_q;
  logic [gtr_pkg::ORIGIN_W-1:0]    ox_q, oy_q;
  logic [gtr_pkg::COLOR_W-1:0]     col_q;

  logic                            accept, is_draw, we;
  gtr_pkg::gtr_entry_t             wr_data, rd_data;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  gtr_pkg::gtr_hit_t               hit;
  logic                            scan_busy;

  assign req_i.ready = (state_q == T_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign is_draw     = (req_i.req_type == gtr_pkg::REQ_DRAW);
  assign we          = accept && !is_draw
                       && (CMP_W'(req_i.entry_index) < CMP_W'(TABLE_ENTRIES));

  assign wr_data.code = req_i.entry_code;
  assign wr_data.size = {gtr_pkg::clamp_dim_m1(req_i.glyph_height, GLYPH_DIM),
                         gtr_pkg::clamp_dim_m1(req_i.glyph_width, GLYPH_DIM)};
  assign wr_data.bits = req_i.glyph_bits;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:   if (accept && is_draw) state_d = T_SEARCH;
      T_SEARCH: if (hit.done) state_d = T_SCAN;
      T_SCAN:   if (!scan_busy) state_d = T_IDLE;
      default:  state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_draw) begin
      ox_q  <= req_i.origin_x;
      oy_q  <= req_i.origin_y;
      col_q <= req_i.ink_color;
    end
  end

  gtr_glyph_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (IDX_W'(req_i.entry_index)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gtr_search #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && is_draw),
    .code_i    (req_i.char_code),
    .count_i   (count_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .hit_o     (hit)
  );

  gtr_dot_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hit_i      (hit),
    .entry_i    (rd_data),
    .origin_x_i (ox_q),
    .origin_y_i (oy_q),
    .color_i    (col_q),
    .busy_o     (scan_busy),
    .pix        (pix_o)
  );

endmodule

>>> src/gtr_glyph_mem.sv
// Glyph entry table: one write port, one registered read port.
// Depends on gtr_pkg.
`timescale 1ns / 1ps

module gtr_glyph_mem #(
  parameter int TABLE_ENTRIES = gtr_pkg::GTR_TABLE_ENTRIES,
  parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  gtr_pkg::gtr_entry_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output gtr_pkg::gtr_entry_t rd_data_o
);

  gtr_pkg::gtr_entry_t mem [TABLE_ENTRIES];
  gtr_pkg::gtr_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> src/gtr_search.sv
// Binary search sequencer over the glyph table; each probe is a registered read.
// Depends on gtr_pkg; drives the read port of gtr_glyph_mem.
`timescale 1ns / 1ps

module gtr_search #(
  parameter int TABLE_ENTRIES = gtr_pkg::GTR_TABLE_ENTRIES,
  parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gtr_pkg::CODE_W-1:0]    code_i,
  input  logic [gtr_pkg::CFG_W-1:0]     count_i,
  output logic                          rd_en_o,
  output logic [IDX_W-1:0]              rd_addr_o,
  input  gtr_pkg::gtr_entry_t           rd_data_i,
  output gtr_pkg::gtr_hit_t             hit_o
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > gtr_pkg::CFG_W) ? CNT_W : gtr_pkg::CFG_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [CNT_W-1:0]            lo_q, lo_d, hi_q, hi_d;   // hi is exclusive
  logic [IDX_W-1:0]            mid_q, mid_d;
  logic [gtr_pkg::CODE_W-1:0]  code_q, code_d;
  logic [CNT_W:0]              sum;
  logic [CMP_W-1:0]            cnt_ext;
  logic [CNT_W-1:0]            n_clamped;

  assign cnt_ext   = CMP_W'(count_i);
  assign n_clamped = (cnt_ext > CMP_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                       : CNT_W'(cnt_ext);
  assign sum       = (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(hi_q) - (CNT_W + 1)'(1);

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    code_d    = code_q;
    rd_en_o   = 1'b0;
    rd_addr_o = IDX_W'(sum >> 1);
    hit_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          lo_d    = '0;
          hi_d    = n_clamped;
          code_d  = code_i;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q >= hi_q) begin
          hit_o.done = 1'b1;
          state_d    = S_IDLE;
        end else begin
          rd_en_o = 1'b1;
          mid_d   = IDX_W'(sum >> 1);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data_i.code == code_q) begin
          hit_o.done  = 1'b1;
          hit_o.found = 1'b1;
          state_d     = S_IDLE;
        end else begin
          if (rd_data_i.code < code_q) begin
            lo_d = CNT_W'(mid_q) + CNT_W'(1);
          end else begin
            hi_d = CNT_W'(mid_q);
          end
          state_d = S_PROBE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    code_q <= code_d;
  end

endmodule

>>> src/gtr_dot_scan.sv
// Dot scanner: steps the clipped bitmap one position a cycle, held at a set dot
// on pix stalls; emits pixel items via an output register. Depends on gtr_pkg, gtr_pix_if.
`timescale 1ns / 1ps

module gtr_dot_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gtr_pkg::gtr_hit_t             hit_i,
  input  gtr_pkg::gtr_entry_t           entry_i,
  input  logic [gtr_pkg::ORIGIN_W-1:0]  origin_x_i,
  input  logic [gtr_pkg::ORIGIN_W-1:0]  origin_y_i,
  input  logic [gtr_pkg::COLOR_W-1:0]   color_i,
  output logic                          busy_o,
  gtr_pix_if.source                     pix
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_NONE = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [gtr_pkg::BITMAP_W-1:0]    rem_q, rem_d, rem_clr, masked;
  logic [gtr_pkg::POS_W-1:0]       pos_q, pos_d;
  logic                            found_q, found_d;
  logic [gtr_pkg::ORIGIN_W-1:0]    ox_q, ox_d, oy_q, oy_d;
  logic [gtr_pkg::COLOR_W-1:0]     col_q, col_d;

  logic                            ovld_q, ovld_d;
  logic [gtr_pkg::PIX_W-1:0]       px_q, px_d, py_q, py_d;
  logic [gtr_pkg::COLOR_W-1:0]     pc_q, pc_d;
  logic                            pv_q, pv_d, pf_q, pf_d, pl_q, pl_d;
  logic                            out_free;

  // clip to glyph width and height; bit 8y+x is row y, column x
  always_comb begin
    for (int i = 0; i < gtr_pkg::BITMAP_W; i++) begin
      masked[i] = entry_i.bits[i] && (3'(i % 8) <= entry_i.size[2:0])
                  && (3'(i / 8) <= entry_i.size[5:3]);
    end
  end

  assign rem_clr  = rem_q & ~(gtr_pkg::BITMAP_W'(1) << pos_q);
  assign out_free = !ovld_q || pix.ready;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    found_d = found_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    col_d   = col_q;
    ovld_d  = ovld_q && !pix.ready;
    px_d    = px_q;
    py_d    = py_q;
    pc_d    = pc_q;
    pv_d    = pv_q;
    pf_d    = pf_q;
    pl_d    = pl_q;
    unique case (state_q)
      S_IDLE: begin
        if (hit_i.done) begin
          found_d = hit_i.found;
          ox_d    = origin_x_i;
          oy_d    = origin_y_i;
          col_d   = color_i;
          pos_d   = '0;
          rem_d   = hit_i.found ? masked : '0;
          state_d = (hit_i.found && masked != '0) ? S_RUN : S_NONE;
        end
      end
      S_RUN: begin
        if (rem_q[pos_q]) begin
          if (out_free) begin
            ovld_d = 1'b1;
            px_d   = gtr_pkg::PIX_W'(ox_q) + gtr_pkg::PIX_W'(pos_q[2:0]);
            py_d   = gtr_pkg::PIX_W'(oy_q) + gtr_pkg::PIX_W'(pos_q[5:3]);
            pc_d   = col_q;
            pv_d   = 1'b1;
            pf_d   = 1'b1;
            pl_d   = (rem_clr == '0);
            rem_d  = rem_clr;
            pos_d  = pos_q + 1'b1;
            if (rem_clr == '0) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_NONE: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          px_d    = '0;
          py_d    = '0;
          pc_d    = '0;
          pv_d    = 1'b0;
          pf_d    = found_q;
          pl_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    col_q   <= col_d;
    px_q    <= px_d;
    py_q    <= py_d;
    pc_q    <= pc_d;
    pv_q    <= pv_d;
    pf_q    <= pf_d;
    pl_q    <= pl_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign pix.valid       = ovld_q;
  assign pix.pixel_x     = px_q;
  assign pix.pixel_y     = py_q;
  assign pix.pixel_color = pc_q;
  assign pix.pixel_valid = pv_q;
  assign pix.glyph_found = pf_q;
  assign pix.last        = pl_q;

endmodule
